// ===== hdl/fir_filter_11tap_saturating_macros.svh =====
// assertion macros for the 11-tap fir filter
`ifndef FIR_FILTER_11TAP_SATURATING_MACROS_SVH
`define FIR_FILTER_11TAP_SATURATING_MACROS_SVH

// same-cycle implication, checked out of reset
`define FIR11_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir11 same-cycle check failed");

// next-cycle implication, checked out of reset
`define FIR11_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir11 next-cycle check failed");

`endif

// ===== hdl/fir11_pkg.sv =====
// types and constants shared by the 11-tap fir filter modules
package fir11_pkg;

    localparam int NUM_TAPS = 11;
    localparam int TAP_IDX_W = 4;
    localparam int COEF_W = 8;
    localparam int COUNT_W = 4;
    // extra bits that an 11-term sum needs over one term
    localparam int SUM_GROWTH = 4;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd11;
    localparam logic [COUNT_W-1:0] PRE_FULL_COUNT = 4'd10;

    // pipeline control from the handshake logic
    typedef struct packed {
        logic accept;
        logic advance;
    } pipe_ctrl_t;

    // delay line status seen by the top level
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               full;
    } taps_status_t;

    // symmetric coefficient set
    function automatic logic signed [COEF_W-1:0] coef_of(input logic [TAP_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = -8'sd1;
            4'd1:    c = -8'sd4;
            4'd2:    c = -8'sd7;
            4'd3:    c = 8'sd16;
            4'd4:    c = 8'sd70;
            4'd5:    c = 8'sd101;
            4'd6:    c = 8'sd70;
            4'd7:    c = 8'sd16;
            4'd8:    c = -8'sd7;
            4'd9:    c = -8'sd4;
            4'd10:   c = -8'sd1;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/fir11_taps.sv =====
// delay line, valid sample count and per-transaction output flag
module fir11_taps
    import fir11_pkg::*;
#(
    parameter int SAMPLE_BITS = 9,
    parameter int INPUT_SHIFT = 4,
    parameter int TAP_W = SAMPLE_BITS - INPUT_SHIFT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pipe_ctrl_t                          ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                valid_in,
    output logic        [NUM_TAPS-1:0][TAP_W-1:0] taps,
    output logic                                flag,
    output taps_status_t                        status
);

    logic [NUM_TAPS-1:0][TAP_W-1:0] delay_reg;
    logic [NUM_TAPS-1:0][TAP_W-1:0] delay_next;
    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;
    logic                           flag_reg;
    logic                           flag_next;
    logic signed [SAMPLE_BITS-1:0]  sample_scaled;

    // scaled sample entering tap 0
    assign sample_scaled = sample_in >>> INPUT_SHIFT;

    // shift on a valid sample, count up to full
    always_comb
    begin
        delay_next = delay_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (ctrl.accept)
        begin
            flag_next = valid_in && (count_reg >= PRE_FULL_COUNT);
            if (valid_in)
            begin
                for (int i = NUM_TAPS - 1; i > 0; i--)
                begin
                    delay_next[i] = delay_reg[i-1];
                end
                delay_next[0] = sample_scaled[TAP_W-1:0];
                if (count_reg != FULL_COUNT)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            delay_reg <= delay_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign taps          = delay_reg;
    assign flag          = flag_reg;
    assign status.count  = count_reg;
    assign status.full   = (count_reg == FULL_COUNT);

endmodule

// ===== hdl/fir11_mac.sv =====
// coefficient products, sum, output scaling, saturation and result register
module fir11_mac
    import fir11_pkg::*;
#(
    parameter int SAMPLE_BITS = 9,
    parameter int INPUT_SHIFT = 4,
    parameter int PRODUCT_SHIFT = 6,
    parameter int TAP_W = SAMPLE_BITS - INPUT_SHIFT
)
(
    input  logic                                  clk,
    input  pipe_ctrl_t                            ctrl,
    input  logic        [NUM_TAPS-1:0][TAP_W-1:0] taps,
    input  logic                                  flag,
    output logic signed [SAMPLE_BITS-1:0]         filtered_out,
    output logic                                  valid_out
);

    localparam int PROD_W = TAP_W + COEF_W;
    localparam int ACC_W = PROD_W + SUM_GROWTH;
    localparam int OUT_SCALE = PRODUCT_SHIFT + INPUT_SHIFT + 1 - SAMPLE_BITS;
    localparam int LSH = (OUT_SCALE > 0) ? OUT_SCALE : 0;
    localparam int RSH = (OUT_SCALE < 0) ? -OUT_SCALE : 0;
    localparam int SCALED_W = ACC_W + LSH;

    logic signed [PROD_W-1:0]      prod_shifted [NUM_TAPS];
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_rsh;
    logic signed [SCALED_W-1:0]    scaled;
    logic                          in_range;
    logic signed [SAMPLE_BITS-1:0] sat_value;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          valid_reg;

    // one constant multiply per tap, floor-shifted
    for (genvar g = 0; g < NUM_TAPS; g++)
    begin : g_tap
        logic signed [PROD_W-1:0] tap_ext;
        logic signed [PROD_W-1:0] coef_ext;
        logic signed [PROD_W-1:0] prod;
        assign tap_ext  = PROD_W'($signed(taps[g]));
        assign coef_ext = PROD_W'(coef_of(TAP_IDX_W'(g)));
        assign prod     = tap_ext * coef_ext;
        assign prod_shifted[g] = prod >>> PRODUCT_SHIFT;
    end

    // sum of the shifted products
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            acc = acc + ACC_W'(prod_shifted[i]);
        end
    end

    // output scaling
    assign acc_rsh = acc >>> RSH;
    assign scaled  = SCALED_W'(acc_rsh) <<< LSH;

    // saturate to the sample range
    assign in_range = (scaled[SCALED_W-1:SAMPLE_BITS-1] == '0)
                   || (scaled[SCALED_W-1:SAMPLE_BITS-1] == '1);

    always_comb
    begin
        if (in_range)
        begin
            sat_value = scaled[SAMPLE_BITS-1:0];
        end
        else if (scaled[SCALED_W-1])
        begin
            sat_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // result register, loaded as the item moves out of the delay stage
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            filtered_reg <= sat_value;
            valid_reg    <= flag;
        end
    end

    assign filtered_out = filtered_reg;
    assign valid_out    = valid_reg;

endmodule

// ===== hdl/fir_filter_11tap_saturating.sv =====
// 11-tap saturating fir filter, top level with transaction handshake
// One result transaction per input transaction, sustained at one per clock cycle while
// the output does not stall. The delay line register takes the sample, then the eleven
// constant multiplies, the sum and the saturation settle into the result register.
// Input is stalled only while both the delay stage and the result register hold
// transactions and the output side stalls. Invalid samples (valid_in low) leave the
// delay line untouched but still give a result computed from it, with valid_out low.
`include "fir_filter_11tap_saturating_macros.svh"

module fir_filter_11tap_saturating
    import fir11_pkg::*;
#(
    parameter int SAMPLE_BITS = 9,
    parameter int INPUT_SHIFT = 4,
    parameter int PRODUCT_SHIFT = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          valid_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered_out,
    output logic                          valid_out
);

    localparam int TAP_W = SAMPLE_BITS - INPUT_SHIFT;

    logic                           stage_a_reg;
    logic                           stage_a_next;
    logic                           stage_b_reg;
    logic                           stage_b_next;
    pipe_ctrl_t                     ctrl;
    taps_status_t                   status;
    logic [NUM_TAPS-1:0][TAP_W-1:0] taps;
    logic                           flag;

    // handshake and pipeline advance
    assign in_stall     = stage_a_reg && stage_b_reg && out_stall;
    assign ctrl.accept  = in_valid && !in_stall;
    assign ctrl.advance = stage_a_reg && (!stage_b_reg || !out_stall);
    assign out_valid    = stage_b_reg;

    always_comb
    begin
        stage_a_next = stage_a_reg;
        stage_b_next = stage_b_reg;
        if (ctrl.accept)
        begin
            stage_a_next = 1'b1;
        end
        else if (ctrl.advance)
        begin
            stage_a_next = 1'b0;
        end
        if (ctrl.advance)
        begin
            stage_b_next = 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            stage_b_next = 1'b0;
        end
    end

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_a_reg <= 1'b0;
            stage_b_reg <= 1'b0;
        end
        else
        begin
            stage_a_reg <= stage_a_next;
            stage_b_reg <= stage_b_next;
        end
    end

    fir11_taps #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INPUT_SHIFT (INPUT_SHIFT),
        .TAP_W       (TAP_W)
    ) u_taps (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (sample_in),
        .valid_in  (valid_in),
        .taps      (taps),
        .flag      (flag),
        .status    (status)
    );

    fir11_mac #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .INPUT_SHIFT   (INPUT_SHIFT),
        .PRODUCT_SHIFT (PRODUCT_SHIFT),
        .TAP_W         (TAP_W)
    ) u_mac (
        .clk          (clk),
        .ctrl         (ctrl),
        .taps         (taps),
        .flag         (flag),
        .filtered_out (filtered_out),
        .valid_out    (valid_out)
    );

    // checks
    `FIR11_ASSERT_SAME(a_valid_out_full, clk, rst_n, out_valid && valid_out, status.full)
    `FIR11_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, status.count <= FULL_COUNT)
    `FIR11_ASSERT_NEXT(a_hold_on_invalid, clk, rst_n, ctrl.accept && !valid_in, $stable(taps))
    `FIR11_ASSERT_NEXT(a_result_follows, clk, rst_n, ctrl.advance, out_valid)

endmodule
